@@ src/srr_pkg.sv @@
// shared types, constants and helpers of the selective-repeat receiver
// no dependencies; every other file imports this package
package srr_pkg;

   localparam int MAX_WINDOW = 6;
   localparam int LAST_CHUNK = 2;
   localparam logic [63:0] ACK_FILL8 = 64'h3030_3030_3030_3030;
   localparam logic [31:0] ACK_FILL4 = 32'h3030_3030;
   localparam logic signed [31:0] ACK_CK_OFFSET = 32'sd960;
   localparam logic [2:0] WINDOW_RESET = 3'd6;

   localparam logic RESULT_DELIVER = 1'b0;
   localparam logic RESULT_ACK = 1'b1;

   typedef struct packed {
      logic signed [31:0] sequence_number;
      logic signed [31:0] ack_number;
      logic signed [31:0] packet_checksum;
      logic [63:0] payload_bytes_0_7;
      logic [63:0] payload_bytes_8_15;
      logic [31:0] payload_bytes_16_19;
   } req_payload_type;

   typedef struct packed {
      logic result_kind;
      logic [63:0] out_bytes_0_7;
      logic [63:0] out_bytes_8_15;
      logic [31:0] out_bytes_16_19;
      logic out_sequence;
      logic signed [31:0] out_ack;
      logic signed [31:0] out_checksum;
      logic last;
   } rsp_payload_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic accum;
      logic [1:0] chunk;
      logic store;
      logic read;
      logic emit_data;
      logic emit_ack;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic sum_ok;
      logic win_hit;
      logic base_held;
      logic out_free;
   } dp_stat_type;

   // signed sum of the eight bytes of a word
   function automatic logic [31:0] chunk_sum(input logic [63:0] word);
      logic [31:0] s;
      s = '0;
      for (int i = 0; i < 8; i++) begin
         s = s + {{24{word[8*i+7]}}, word[8*i +: 8]};
      end
      return s;
   endfunction

endpackage

@@ src/srr_req_if.sv @@
// packet input channel of the selective-repeat receiver
// depends on srr_pkg
interface srr_req_if import srr_pkg::*;;
   logic valid;
   logic ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

@@ src/srr_rsp_if.sv @@
// result channel of the selective-repeat receiver
// depends on srr_pkg
interface srr_rsp_if import srr_pkg::*;;
   logic valid;
   logic ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

@@ src/selective_repeat_receiver.sv @@
// Selective-repeat ARQ receiver. Each packet item on req_ch is checked against
// its checksum (32-bit wrapping sum of sequence number, ack number and the twenty
// payload bytes taken as signed); a corrupted packet gives no result. A good packet
// inside the receive window [base, base + window) mod SEQ_SPACE is buffered unless
// its slot is already held, then the in-order run of held slots from the base is
// delivered on rsp_ch as payload items (result_kind 0), each slot released and the
// base advanced. Every good packet ends with an ACK item (result_kind 1, last 1,
// bytes all 0x30, out_ack the sequence number, out_checksum that plus 960).
// The window width is written through csr_window_size; the user must write it only
// while the block is idle, which the block does not enforce. It is capped at 6 and
// at SEQ_SPACE/2, and 0 gives an empty window. A packet is loaded in IDLE, summed
// in SUM by the checksum accumulator, which folds one 8-byte chunk of the payload
// per cycle, and checked in CHECK. The slot memory has a registered read port: a
// held slot is read in LOOKUP and emitted in FILL, the next read waiting for the
// result register. A new packet is accepted while the previous ACK still waits in
// the result register; FILL and ACK wait while the result side stalls. Held marks
// are flip-flops cleared at reset, so no clearing pass is needed.

// depends on srr_pkg, srr_req_if, srr_rsp_if, srr_ctrl and srr_datapath
module selective_repeat_receiver import srr_pkg::*; #(
   parameter int SEQ_SPACE = 12
) (
   input  logic        clock,
   input  logic        reset,
   srr_req_if.sink     req_ch,
   srr_rsp_if.source   rsp_ch,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_window_size
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   // the window register takes a write in any cycle
   assign csr_ready = 1'b1;

   // sequencer: checksum steps, store, delivery loop, ack
   srr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // packet registers, slot memory, held marks, window base, result register
   srr_datapath #(
      .SEQ_SPACE (SEQ_SPACE)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_payload     (req_ch.payload),
      .cmd             (cmd),
      .stat            (stat),
      .csr_valid       (csr_valid),
      .csr_window_size (csr_window_size),
      .rsp_valid       (rsp_ch.valid),
      .rsp_ready       (rsp_ch.ready),
      .rsp_payload     (rsp_ch.payload)
   );

endmodule

@@ src/srr_ctrl.sv @@
// sequencer of the selective-repeat receiver
// depends on srr_pkg; drives the datapath through dp_cmd_type
module srr_ctrl import srr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   typedef enum logic [2:0] {
      IDLE,
      SUM,
      CHECK,
      LOOKUP,
      FILL,
      ACK
   } state_type;

   state_type  state_ff, state_in;
   logic [1:0] chunk_ff, chunk_in;
   logic [2:0] count_ff, count_in;

   assign req_ready = (state_ff == IDLE);

   always_comb begin
      state_in = state_ff;
      chunk_in = chunk_ff;
      count_in = count_ff;
      cmd = '0;
      cmd.chunk = chunk_ff;
      case (state_ff)
         IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               chunk_in = '0;
               state_in = SUM;
            end
         end
         SUM: begin
            cmd.accum = 1'b1;
            if (chunk_ff == 2'(LAST_CHUNK)) begin
               state_in = CHECK;
            end else begin
               chunk_in = chunk_ff + 2'd1;
            end
         end
         CHECK: begin
            count_in = '0;
            if (!stat.sum_ok) begin
               state_in = IDLE;
            end else if (stat.win_hit) begin
               cmd.store = 1'b1;
               state_in = LOOKUP;
            end else begin
               state_in = ACK;
            end
         end
         LOOKUP: begin
            if (stat.base_held && (count_ff < 3'(MAX_WINDOW))) begin
               cmd.read = 1'b1;
               count_in = count_ff + 3'd1;
               state_in = FILL;
            end else begin
               state_in = ACK;
            end
         end
         FILL: begin
            if (stat.out_free) begin
               cmd.emit_data = 1'b1;
               state_in = LOOKUP;
            end
         end
         ACK: begin
            if (stat.out_free) begin
               cmd.emit_ack = 1'b1;
               state_in = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         chunk_ff <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         chunk_ff <= chunk_in;
         count_ff <= count_in;
      end
   end

`ifndef ASSERT_OFF
   // deliveries per packet stay within the window limit
   a_count_limit: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 3'(MAX_WINDOW))
      else $error("delivery count over limit");

   // a delivery is only issued from a slot that is held
   a_read_held: assert property (@(posedge clock) disable iff (reset)
      cmd.read |-> stat.base_held)
      else $error("read of a slot that is not held");

   // a corrupted packet returns straight to idle
   a_bad_drop: assert property (@(posedge clock) disable iff (reset)
      (state_ff == CHECK && !stat.sum_ok) |=> state_ff == IDLE)
      else $error("corrupted packet not dropped");
`endif

endmodule

@@ src/srr_datapath.sv @@
// packet registers, checksum accumulator, slot store and result register
// depends on srr_pkg; commanded by srr_ctrl
module srr_datapath import srr_pkg::*; #(
   parameter int SEQ_SPACE = 12
) (
   input  logic            clock,
   input  logic            reset,
   input  req_payload_type req_payload,
   input  dp_cmd_type      cmd,
   output dp_stat_type     stat,
   input  logic            csr_valid,
   input  logic [2:0]      csr_window_size,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload
);

   localparam int IDX_W = $clog2(SEQ_SPACE);
   localparam int WIN_CAP = (MAX_WINDOW < SEQ_SPACE / 2) ? MAX_WINDOW : SEQ_SPACE / 2;
   localparam logic [31:0] SPACE_U = 32'(SEQ_SPACE);
   localparam logic [IDX_W:0] SPACE_X = (IDX_W + 1)'(SEQ_SPACE);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SEQ_SPACE - 1);

   req_payload_type pkt_ff;
   logic [31:0]     acc_ff, acc_in;
   logic [2:0]      window_ff;
   logic [IDX_W-1:0] base_ff;
   logic [SEQ_SPACE-1:0] held_ff;
   logic [159:0]    slot_mem [SEQ_SPACE];
   logic [159:0]    rd_ff;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_ff;

   logic [IDX_W-1:0] seq_idx;
   logic [IDX_W:0]   diff;
   logic [IDX_W:0]   off;
   logic [2:0]       eff_window;
   logic [63:0]      chunk_word;

   assign seq_idx = pkt_ff.sequence_number[IDX_W-1:0];
   assign eff_window = (window_ff > 3'(WIN_CAP)) ? 3'(WIN_CAP) : window_ff;

   // distance of the sequence number past the base, modulo the space
   always_comb begin
      diff = {1'b0, seq_idx} - {1'b0, base_ff};
      off = diff[IDX_W] ? (diff + SPACE_X) : diff;
   end

   always_comb begin
      case (cmd.chunk)
         2'd0: chunk_word = pkt_ff.payload_bytes_0_7;
         2'd1: chunk_word = pkt_ff.payload_bytes_8_15;
         default: chunk_word = {32'b0, pkt_ff.payload_bytes_16_19};
      endcase
   end

   always_comb begin
      acc_in = acc_ff;
      if (cmd.load) begin
         acc_in = req_payload.sequence_number + req_payload.ack_number;
      end else if (cmd.accum) begin
         acc_in = acc_ff + chunk_sum(chunk_word);
      end
   end

   always_comb begin
      stat.sum_ok = (acc_ff == pkt_ff.packet_checksum);
      stat.win_hit = ($unsigned(pkt_ff.sequence_number) < SPACE_U)
                     && (off < (IDX_W + 1)'(eff_window));
      stat.base_held = held_ff[base_ff];
      stat.out_free = !rsp_valid_ff || rsp_ready;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         pkt_ff <= req_payload;
      end
      acc_ff <= acc_in;
   end

   // slot store
   always_ff @(posedge clock) begin
      if (cmd.store && !held_ff[seq_idx]) begin
         slot_mem[seq_idx] <= {pkt_ff.payload_bytes_16_19, pkt_ff.payload_bytes_8_15,
                               pkt_ff.payload_bytes_0_7};
      end
      if (cmd.read) begin
         rd_ff <= slot_mem[base_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
         base_ff <= '0;
         window_ff <= WINDOW_RESET;
      end else begin
         if (csr_valid) begin
            window_ff <= csr_window_size;
         end
         if (cmd.store) begin
            held_ff[seq_idx] <= 1'b1;
         end
         if (cmd.read) begin
            held_ff[base_ff] <= 1'b0;
            base_ff <= (base_ff == LAST_IDX) ? '0 : base_ff + IDX_W'(1);
         end
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit_data || cmd.emit_ack) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_data) begin
         rsp_ff.result_kind <= RESULT_DELIVER;
         rsp_ff.out_bytes_0_7 <= rd_ff[63:0];
         rsp_ff.out_bytes_8_15 <= rd_ff[127:64];
         rsp_ff.out_bytes_16_19 <= rd_ff[159:128];
         rsp_ff.out_sequence <= 1'b0;
         rsp_ff.out_ack <= '0;
         rsp_ff.out_checksum <= '0;
         rsp_ff.last <= 1'b0;
      end else if (cmd.emit_ack) begin
         rsp_ff.result_kind <= RESULT_ACK;
         rsp_ff.out_bytes_0_7 <= ACK_FILL8;
         rsp_ff.out_bytes_8_15 <= ACK_FILL8;
         rsp_ff.out_bytes_16_19 <= ACK_FILL4;
         rsp_ff.out_sequence <= 1'b0;
         rsp_ff.out_ack <= pkt_ff.sequence_number;
         rsp_ff.out_checksum <= pkt_ff.sequence_number + ACK_CK_OFFSET;
         rsp_ff.last <= 1'b1;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef ASSERT_OFF
   // a pending result is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_data || cmd.emit_ack) |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten");

   // a delivered slot is released and the base moves on
   a_release: assert property (@(posedge clock) disable iff (reset)
      cmd.read |=> (!held_ff[$past(base_ff)] && base_ff != $past(base_ff)))
      else $error("delivered slot not released");

   // store and delivery read never share a cycle
   a_store_read: assert property (@(posedge clock) disable iff (reset)
      !(cmd.store && cmd.read))
      else $error("store and read together");

   // a stored packet leaves its slot held
   a_store_held: assert property (@(posedge clock) disable iff (reset)
      cmd.store |=> held_ff[$past(seq_idx)])
      else $error("stored slot not held");
`endif

endmodule

@@ verif/selective_repeat_receiver_tb.sv @@
`timescale 1ns / 100ps
// testbench of the selective-repeat receiver: directed packets, then random phases, most
// under random idling; depends on srr_pkg, srr_req_if, srr_rsp_if and the rtl top

module selective_repeat_receiver_tb import srr_pkg::*;;

   localparam int unsigned SEQ_SPACE = 12;
   localparam int ITEMS_PER_PHASE = 50;
   localparam int SETTLE_CYCLES = 16;
   localparam int TAIL_CYCLES = 32;
   localparam int CYCLE_LIMIT = 400000;
   localparam int REPORT_CAP = 100;

   localparam logic [63:0] B_ZERO = 64'h0;
   localparam logic [63:0] B_ONES = 64'hffff_ffff_ffff_ffff;
   localparam logic [63:0] B_SIGN = 64'h8080_8080_8080_8080;
   localparam logic [63:0] B_MAXP = 64'h7f7f_7f7f_7f7f_7f7f;
   localparam logic [63:0] B_ALT = 64'h55aa_55aa_55aa_55aa;

   typedef enum logic [1:0] {ROW_PACKET, ROW_CORRUPT, ROW_WINDOW} row_kind_type;

   // one directed step; when typed is set the results are written out in the row
   typedef struct packed {
      row_kind_type kind;
      logic [31:0] seq;
      logic [31:0] ack;
      logic [63:0] b0;
      logic [63:0] b1;
      logic [31:0] b2;
      logic [2:0] window;
      logic typed;
      logic [31:0] want_ack;
      logic [31:0] want_ck;
   } plan_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_valid;
   logic csr_ready;
   logic [2:0] csr_window_size;

   srr_req_if req_bus();
   srr_rsp_if rsp_bus();

   selective_repeat_receiver #(.SEQ_SPACE(SEQ_SPACE)) uut (
      .clock(clock),
      .reset(reset),
      .req_ch(req_bus),
      .rsp_ch(rsp_bus),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_window_size(csr_window_size)
   );

   always #5 clock = ~clock;

   // receiver state as the testbench sees it
   logic [63:0] slot_low [SEQ_SPACE];
   logic [63:0] slot_mid [SEQ_SPACE];
   logic [31:0] slot_high [SEQ_SPACE];
   bit slot_held [SEQ_SPACE];
   int unsigned win_base = 0;
   logic [2:0] window_reg = WINDOW_RESET;

   rsp_payload_type due_results [$];
   int mismatch_count = 0;
   int cycle_count = 0;
   bit no_idle = 1'b0;

   plan_row_type directed_plan [25] = '{
      '{ROW_PACKET, 32'd0, 32'd0, B_ZERO, B_ZERO, 32'h0, 3'd0, 1'b0, 32'd0, 32'd0},
      '{ROW_CORRUPT, 32'd1, 32'hffff_ffff, B_ONES, B_ONES, 32'hffff_ffff, 3'd0, 1'b1,
        32'd0, 32'd0},
      '{ROW_PACKET, 32'd2, 32'hffff_ffff, B_ONES, B_ONES, 32'hffff_ffff, 3'd0, 1'b0,
        32'd0, 32'd0},
      '{ROW_PACKET, 32'd2, 32'd0, B_ALT, B_ALT, 32'h55aa_55aa, 3'd0, 1'b0, 32'd0, 32'd0},
      '{ROW_PACKET, 32'd1, 32'h7fff_ffff, B_SIGN, B_SIGN, 32'h8080_8080, 3'd0, 1'b0,
        32'd0, 32'd0},
      '{ROW_PACKET, 32'hffff_ffff, 32'd0, B_MAXP, B_MAXP, 32'h7f7f_7f7f, 3'd0, 1'b1,
        32'hffff_ffff, 32'd959},
      '{ROW_PACKET, 32'h8000_0000, 32'h8000_0000, B_ZERO, B_ONES, 32'h0, 3'd0, 1'b1,
        32'h8000_0000, 32'h8000_03c0},
      '{ROW_PACKET, 32'h7fff_ffff, 32'hffff_ffff, B_ONES, B_ZERO, 32'hffff_ffff, 3'd0,
        1'b1, 32'h7fff_ffff, 32'h8000_03bf},
      '{ROW_PACKET, 32'd12, 32'd5, B_ALT, B_SIGN, 32'h0, 3'd0, 1'b1, 32'd12, 32'd972},
      '{ROW_PACKET, 32'd0, 32'd0, B_MAXP, B_ALT, 32'h1234_5678, 3'd0, 1'b0, 32'd0, 32'd0},
      '{ROW_PACKET, 32'd8, 32'd7, B_SIGN, B_MAXP, 32'h8000_007f, 3'd0, 1'b0, 32'd0, 32'd0},
      '{ROW_PACKET, 32'd9, 32'd7, B_ONES, B_ALT, 32'h0, 3'd0, 1'b0, 32'd0, 32'd0},
      '{ROW_WINDOW, 32'd0, 32'd0, B_ZERO, B_ZERO, 32'h0, 3'd0, 1'b0, 32'd0, 32'd0},
      '{ROW_PACKET, 32'd3, 32'd1, B_ALT, B_ALT, 32'h0, 3'd0, 1'b1, 32'd3, 32'd963},
      '{ROW_WINDOW, 32'd0, 32'd0, B_ZERO, B_ZERO, 32'h0, 3'd7, 1'b0, 32'd0, 32'd0},
      '{ROW_PACKET, 32'd4, 32'd0, B_ONES, B_SIGN, 32'h4444_4444, 3'd0, 1'b0, 32'd0, 32'd0},
      '{ROW_PACKET, 32'd5, 32'd0, B_SIGN, B_ONES, 32'h5555_5555, 3'd0, 1'b0, 32'd0, 32'd0},
      '{ROW_PACKET, 32'd6, 32'd0, B_MAXP, B_ZERO, 32'h6666_6666, 3'd0, 1'b0, 32'd0, 32'd0},
      '{ROW_PACKET, 32'd7, 32'd0, B_ZERO, B_MAXP, 32'h7777_7777, 3'd0, 1'b0, 32'd0, 32'd0},
      '{ROW_PACKET, 32'd3, 32'd0, B_ALT, B_ONES, 32'h3333_3333, 3'd0, 1'b0, 32'd0, 32'd0},
      '{ROW_WINDOW, 32'd0, 32'd0, B_ZERO, B_ZERO, 32'h0, 3'd1, 1'b0, 32'd0, 32'd0},
      '{ROW_PACKET, 32'd10, 32'd2, B_ONES, B_ONES, 32'h0, 3'd0, 1'b0, 32'd0, 32'd0},
      '{ROW_PACKET, 32'd9, 32'd2, B_SIGN, B_ZERO, 32'h9999_9999, 3'd0, 1'b0, 32'd0, 32'd0},
      '{ROW_WINDOW, 32'd0, 32'd0, B_ZERO, B_ZERO, 32'h0, 3'd6, 1'b0, 32'd0, 32'd0},
      '{ROW_CORRUPT, 32'd11, 32'd0, B_ALT, B_ALT, 32'haa55_aa55, 3'd0, 1'b1, 32'd0, 32'd0}
   };

   logic [2:0] phase_windows [8] = '{3'd1, 3'd6, 3'd0, 3'd7, 3'd3, 3'd2, 3'd5, 3'd4};

   // wrapping sum of sequence, ack and the twenty payload bytes taken as signed
   function automatic logic [31:0] packet_sum(input req_payload_type p);
      logic [159:0] bytes;
      logic [31:0] s;
      bytes = {p.payload_bytes_16_19, p.payload_bytes_8_15, p.payload_bytes_0_7};
      s = p.sequence_number + p.ack_number;
      for (int i = 0; i < 20; i++) begin
         s = s + {{24{bytes[8*i+7]}}, bytes[8*i +: 8]};
      end
      return s;
   endfunction

   // a nonzero damage mask spoils the checksum
   function automatic req_payload_type seal_packet(input logic [31:0] seq,
                                                   input logic [31:0] ackn,
                                                   input logic [63:0] b0,
                                                   input logic [63:0] b1,
                                                   input logic [31:0] b2,
                                                   input logic [31:0] damage);
      req_payload_type p;
      p.sequence_number = seq;
      p.ack_number = ackn;
      p.packet_checksum = '0;
      p.payload_bytes_0_7 = b0;
      p.payload_bytes_8_15 = b1;
      p.payload_bytes_16_19 = b2;
      p.packet_checksum = packet_sum(p) ^ damage;
      return p;
   endfunction

   function automatic int unsigned open_width();
      int unsigned w;
      w = window_reg;
      if (w > MAX_WINDOW) w = MAX_WINDOW;
      if (w > SEQ_SPACE / 2) w = SEQ_SPACE / 2;
      return w;
   endfunction

   function automatic rsp_payload_type ack_item(input logic [31:0] ackn,
                                                input logic [31:0] ck);
      rsp_payload_type r;
      r.result_kind = RESULT_ACK;
      r.out_bytes_0_7 = ACK_FILL8;
      r.out_bytes_8_15 = ACK_FILL8;
      r.out_bytes_16_19 = ACK_FILL4;
      r.out_sequence = 1'b0;
      r.out_ack = ackn;
      r.out_checksum = ck;
      r.last = 1'b1;
      return r;
   endfunction

   // buffer the packet, release the in-order run from the base, then the ack
   function automatic void absorb_packet(input req_payload_type p,
                                         ref rsp_payload_type outs[$]);
      logic [31:0] seq;
      int unsigned off;
      int n;
      rsp_payload_type r;
      outs = {};
      if (packet_sum(p) != p.packet_checksum) return;
      seq = p.sequence_number;
      if (seq < SEQ_SPACE) begin
         off = (seq + SEQ_SPACE - win_base) % SEQ_SPACE;
         if (off < open_width()) begin
            if (!slot_held[seq]) begin
               slot_low[seq] = p.payload_bytes_0_7;
               slot_mid[seq] = p.payload_bytes_8_15;
               slot_high[seq] = p.payload_bytes_16_19;
               slot_held[seq] = 1'b1;
            end
            n = 0;
            while (n < MAX_WINDOW && slot_held[win_base]) begin
               r.result_kind = RESULT_DELIVER;
               r.out_bytes_0_7 = slot_low[win_base];
               r.out_bytes_8_15 = slot_mid[win_base];
               r.out_bytes_16_19 = slot_high[win_base];
               r.out_sequence = 1'b0;
               r.out_ack = '0;
               r.out_checksum = '0;
               r.last = 1'b0;
               outs.push_back(r);
               slot_held[win_base] = 1'b0;
               win_base = (win_base + 1) % SEQ_SPACE;
               n++;
            end
         end
      end
      outs.push_back(ack_item(seq, seq + ACK_CK_OFFSET));
   endfunction

   function automatic int idle_draw();
      if (no_idle || $urandom_range(0, 3) == 0) return 0;
      return $urandom_range(0, 10);
   endfunction

   function automatic logic [63:0] rand_bytes64();
      case ($urandom_range(0, 7))
         0: return B_ZERO;
         1: return B_ONES;
         2: return B_SIGN;
         3: return B_MAXP;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   task automatic report_mismatch(input string line);
      mismatch_count++;
      if (mismatch_count <= REPORT_CAP) $display("%0t: %s", $time, line);
   endtask

   // valid stays high from one item to the next unless a gap is drawn
   task automatic send_packet(input req_payload_type p);
      int gap;
      gap = idle_draw();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.payload <= p;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // hold the sender until every pending result is in, then let a dropped packet finish
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      while (due_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_window(input logic [2:0] width);
      drain_results();
      csr_valid <= 1'b1;
      csr_window_size <= width;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      window_reg = width;
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // result side: random stalls, each item checked against the oldest pending one
   initial begin : result_monitor
      int stall;
      int item_no;
      rsp_payload_type got;
      rsp_payload_type want;
      item_no = 0;
      rsp_bus.ready <= 1'b0;
      wait (!reset);
      forever begin
         stall = idle_draw();
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         got = rsp_bus.payload;
         if (due_results.size() == 0) begin
            report_mismatch($sformatf("result item %0d arrived with nothing pending", item_no));
         end else begin
            want = due_results.pop_front();
            if (got.result_kind !== want.result_kind)
               report_mismatch($sformatf("item %0d result_kind %h want %h", item_no,
                                         got.result_kind, want.result_kind));
            if (got.out_bytes_0_7 !== want.out_bytes_0_7)
               report_mismatch($sformatf("item %0d out_bytes_0_7 %h want %h", item_no,
                                         got.out_bytes_0_7, want.out_bytes_0_7));
            if (got.out_bytes_8_15 !== want.out_bytes_8_15)
               report_mismatch($sformatf("item %0d out_bytes_8_15 %h want %h", item_no,
                                         got.out_bytes_8_15, want.out_bytes_8_15));
            if (got.out_bytes_16_19 !== want.out_bytes_16_19)
               report_mismatch($sformatf("item %0d out_bytes_16_19 %h want %h", item_no,
                                         got.out_bytes_16_19, want.out_bytes_16_19));
            if (got.out_sequence !== want.out_sequence)
               report_mismatch($sformatf("item %0d out_sequence %h want %h", item_no,
                                         got.out_sequence, want.out_sequence));
            if (got.out_ack !== want.out_ack)
               report_mismatch($sformatf("item %0d out_ack %h want %h", item_no,
                                         got.out_ack, want.out_ack));
            if (got.out_checksum !== want.out_checksum)
               report_mismatch($sformatf("item %0d out_checksum %h want %h", item_no,
                                         got.out_checksum, want.out_checksum));
            if (got.last !== want.last)
               report_mismatch($sformatf("item %0d last %h want %h", item_no,
                                         got.last, want.last));
         end
         item_no++;
      end
   end

   // packet side: directed plan, then random phases each with its own window
   initial begin : packet_source
      plan_row_type row;
      req_payload_type pkt;
      rsp_payload_type outs [$];
      logic [31:0] seq;
      logic [31:0] ackn;
      logic [31:0] damage;
      logic [63:0] b2_word;
      int unsigned w;
      int pick;
      int good_count;
      csr_valid <= 1'b0;
      csr_window_size <= '0;
      req_bus.valid <= 1'b0;
      req_bus.payload <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_plan[r]) begin
         row = directed_plan[r];
         if (row.kind == ROW_WINDOW) begin
            set_window(row.window);
         end else begin
            pkt = seal_packet(row.seq, row.ack, row.b0, row.b1, row.b2,
                              (row.kind == ROW_CORRUPT) ? 32'd1 : 32'd0);
            send_packet(pkt);
            absorb_packet(pkt, outs);
            // written-out rows replace the prediction; a dropped packet gives nothing
            if (row.typed) begin
               outs = {};
               if (row.kind == ROW_PACKET) outs.push_back(ack_item(row.want_ack, row.want_ck));
            end
            foreach (outs[k]) due_results.push_back(outs[k]);
         end
      end

      foreach (phase_windows[ph]) begin
         set_window(phase_windows[ph]);
         no_idle = (ph == 2 || ph == 5);
         good_count = 0;
         while (good_count < ITEMS_PER_PHASE) begin
            pick = $urandom_range(0, 99);
            w = open_width();
            // mostly sequence numbers at or just past the window
            if (pick < 70) seq = (win_base + $urandom_range(0, w + 1)) % SEQ_SPACE;
            else if (pick < 85) seq = $urandom_range(0, SEQ_SPACE - 1);
            else if (pick < 93) seq = $urandom;
            else if (pick < 97) seq = SEQ_SPACE + $urandom_range(0, 8);
            else seq = -$urandom_range(1, 8);
            ackn = ($urandom_range(0, 3) == 0) ? 32'hffff_ffff : $urandom;
            damage = ($urandom_range(0, 6) == 0) ? $urandom_range(1, 32'hffff_ffff) : 32'd0;
            b2_word = rand_bytes64();
            pkt = seal_packet(seq, ackn, rand_bytes64(), rand_bytes64(), b2_word[31:0],
                              damage);
            send_packet(pkt);
            absorb_packet(pkt, outs);
            foreach (outs[k]) due_results.push_back(outs[k]);
            if (damage == 0) good_count++;
         end
      end

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
